// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each check is sampled on the rising
// edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check: the property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Concurrent check of an implication from one cycle to the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wsdf_pkg.sv =====
package wsdf_pkg;

  // Parser phases. Codes 6 and 7 are unused and are handled as frame start.
  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LEN1    = 3'd1,
    PH_LEN2    = 3'd2,
    PH_LEN8    = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  // Reserved bits RSV1..RSV3 of the first header byte.
  localparam logic [7:0] RSV_MASK = 8'h70;
  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  // Byte counts of the multi-byte header fields.
  localparam logic [3:0] LEN16_BYTES = 4'd2;
  localparam logic [3:0] LEN64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // One result produced by the parser for one input byte.
  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    logic       fin;
    logic [3:0] op;
  } wsdf_result_t;

endpackage

// ===== rtl/wsdf_parser.sv =====
module wsdf_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            in_byte,
  output wsdf_pkg::wsdf_result_t res
);

  wsdf_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  header_count_r, header_count_nxt;
  logic [63:0] payload_length_r, payload_length_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;
  logic [63:0] payload_count_r, payload_count_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;

  logic [3:0]  hc_inc;
  logic [63:0] pc_inc;
  logic [7:0]  key_byte;
  logic        ext_done;

  assign hc_inc = header_count_r + 4'd1;
  assign pc_inc = payload_count_r + 64'd1;

  // The first key byte received sits in the top byte of the key register.
  always_comb begin
    unique case (payload_count_r[1:0])
      2'd0: key_byte = mask_key_r[31:24];
      2'd1: key_byte = mask_key_r[23:16];
      2'd2: key_byte = mask_key_r[15:8];
      2'd3: key_byte = mask_key_r[7:0];
    endcase
  end

  assign ext_done = ((phase_r == wsdf_pkg::PH_LEN2) && (hc_inc == wsdf_pkg::LEN16_BYTES)) ||
                    ((phase_r == wsdf_pkg::PH_LEN8) && (hc_inc == wsdf_pkg::LEN64_BYTES));

  always_comb begin
    phase_nxt          = phase_r;
    header_count_nxt   = header_count_r;
    payload_length_nxt = payload_length_r;
    mask_key_nxt       = mask_key_r;
    payload_count_nxt  = payload_count_r;
    fin_nxt            = fin_r;
    opcode_nxt         = opcode_r;
    res.vld            = 1'b0;
    res.kind           = wsdf_pkg::KIND_DATA;
    res.data           = 8'd0;
    res.last           = 1'b0;
    res.fin            = fin_r;
    res.op             = opcode_r;

    unique case (phase_r)
      wsdf_pkg::PH_LEN1: begin
        if (!in_byte[7]) begin
          // A client frame must be masked; stay on the length byte.
          res.vld  = 1'b1;
          res.kind = wsdf_pkg::KIND_ERROR;
        end else begin
          header_count_nxt = 4'd0;
          if (in_byte[6:0] == wsdf_pkg::LEN_EXT16) begin
            payload_length_nxt = 64'd0;
            phase_nxt          = wsdf_pkg::PH_LEN2;
          end else if (in_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
            payload_length_nxt = 64'd0;
            phase_nxt          = wsdf_pkg::PH_LEN8;
          end else begin
            payload_length_nxt = {57'd0, in_byte[6:0]};
            phase_nxt          = wsdf_pkg::PH_KEY;
          end
        end
      end
      wsdf_pkg::PH_LEN2, wsdf_pkg::PH_LEN8: begin
        payload_length_nxt = {payload_length_r[55:0], in_byte};
        header_count_nxt   = hc_inc;
        if (ext_done) begin
          header_count_nxt = 4'd0;
          phase_nxt        = wsdf_pkg::PH_KEY;
        end
      end
      wsdf_pkg::PH_KEY: begin
        mask_key_nxt     = {mask_key_r[23:0], in_byte};
        header_count_nxt = hc_inc;
        if (hc_inc == wsdf_pkg::KEY_BYTES) begin
          header_count_nxt  = 4'd0;
          payload_count_nxt = 64'd0;
          if (payload_length_r == 64'd0) begin
            phase_nxt = wsdf_pkg::PH_START;
            res.vld   = 1'b1;
            res.kind  = wsdf_pkg::KIND_EMPTY;
            res.last  = 1'b1;
          end else begin
            phase_nxt = wsdf_pkg::PH_PAYLOAD;
          end
        end
      end
      wsdf_pkg::PH_PAYLOAD: begin
        payload_count_nxt = pc_inc;
        res.vld           = 1'b1;
        res.data          = in_byte ^ key_byte;
        if (pc_inc == payload_length_r) begin
          res.last  = 1'b1;
          phase_nxt = wsdf_pkg::PH_START;
        end
      end
      default: begin
        if ((in_byte & wsdf_pkg::RSV_MASK) != 8'd0) begin
          res.vld  = 1'b1;
          res.kind = wsdf_pkg::KIND_ERROR;
        end else begin
          fin_nxt            = in_byte[7];
          opcode_nxt         = in_byte[3:0];
          payload_length_nxt = 64'd0;
          payload_count_nxt  = 64'd0;
          mask_key_nxt       = 32'd0;
          header_count_nxt   = 4'd0;
          phase_nxt          = wsdf_pkg::PH_LEN1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= wsdf_pkg::PH_START;
      header_count_r   <= 4'd0;
      payload_length_r <= 64'd0;
      mask_key_r       <= 32'd0;
      payload_count_r  <= 64'd0;
      fin_r            <= 1'b0;
      opcode_r         <= 4'd0;
    end else if (step) begin
      phase_r          <= phase_nxt;
      header_count_r   <= header_count_nxt;
      payload_length_r <= payload_length_nxt;
      mask_key_r       <= mask_key_nxt;
      payload_count_r  <= payload_count_nxt;
      fin_r            <= fin_nxt;
      opcode_r         <= opcode_nxt;
    end
  end

endmodule

// ===== rtl/websocket_frame_deframer_top.sv =====
// WebSocket client-to-server deframer. Each input transfer carries one byte
// of the stream. Header bytes (FIN/opcode, length with optional 16-bit or
// 64-bit extension, mask bit and the four-byte masking key) are absorbed
// without a result; every payload byte comes out unmasked as one result
// transfer, and the final one of the frame has out_last set. A frame of zero
// length gives one empty-frame result with out_last set after its key. A set
// reserved bit or a clear mask bit gives an error result and the offending
// byte is dropped, so the parser retries at the same header field. The block
// takes one byte every cycle: the parser steps on each accepted byte and
// the result lands in an output register in the cycle after the byte's
// transfer. The longest path is the 64-bit payload counter increment and
// its compare against the frame length. Input is stalled only while a
// result is held in the output register and the consumer is stalling it.
`include "assert_macros.svh"

module websocket_frame_deframer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data,
  output logic       out_last,
  output logic       out_fin_flag,
  output logic [3:0] out_op_code
);

  wsdf_pkg::wsdf_result_t res;
  logic       in_take;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r;
  logic [7:0] out_data_r;
  logic       out_last_r;
  logic       out_fin_r;
  logic [3:0] out_op_r;

  // A new byte may enter whenever the output register is free or is being
  // emptied in this same cycle.
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  wsdf_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_take),
    .in_byte (in_byte),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_take && res.vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result payload needs no reset; it is loaded only with a new result.
  always_ff @(posedge clk) begin
    if (in_take && res.vld) begin
      out_kind_r <= res.kind;
      out_data_r <= res.data;
      out_last_r <= res.last;
      out_fin_r  <= res.fin;
      out_op_r   <= res.op;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_data     = out_data_r;
  assign out_last     = out_last_r;
  assign out_fin_flag = out_fin_r;
  assign out_op_code  = out_op_r;

  `ASSERT_CLK(a_free_not_stalled, !out_valid_r |-> !in_stall, "input stalled with empty output")
  `ASSERT_NEXT(a_result_loaded, in_take && res.vld, out_valid_r, "accepted result was lost")
  `ASSERT_CLK(a_error_shape, (out_valid_r && out_kind_r == wsdf_pkg::KIND_ERROR) |-> (!out_last_r && out_data_r == 8'd0), "error result carries data or last")
  `ASSERT_CLK(a_empty_shape, (out_valid_r && out_kind_r == wsdf_pkg::KIND_EMPTY) |-> (out_last_r && out_data_r == 8'd0), "empty frame result malformed")

endmodule

// ===== bench/websocket_frame_deframer_top_tb.sv =====
`timescale 1ns / 100ps

module websocket_frame_deframer_top_tb;

  // The clock runs at a 2 ns period. Reset starts low and, once released,
  // is never asserted again.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data;
  logic out_last;
  logic out_fin_flag;
  logic [3:0] out_op_code;

  always #1 clk = ~clk;

  websocket_frame_deframer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_data(out_data),
    .out_last(out_last),
    .out_fin_flag(out_fin_flag),
    .out_op_code(out_op_code)
  );

  // One result as the parser should present it on the output channel.
  typedef struct packed {
    wsdf_pkg::kind_t kind;
    logic [7:0] data;
    logic last;
    logic fin;
    logic [3:0] op;
  } frame_result_t;

  // The scoreboard keeps its own copy of the parser state. Every byte that
  // the block accepts is run through that copy, and any result it gives is
  // queued until the block hands over the matching transfer.
  class deframe_scoreboard;
    wsdf_pkg::phase_t phase;
    logic [3:0] hdr_cnt;
    logic [63:0] frame_len;
    logic [63:0] byte_cnt;
    logic [31:0] key;
    logic fin;
    logic [3:0] op;
    frame_result_t pending_results[$];
    int mismatches;

    function new();
      phase = wsdf_pkg::PH_START;
      hdr_cnt = '0;
      frame_len = '0;
      byte_cnt = '0;
      key = '0;
      fin = 1'b0;
      op = '0;
      mismatches = 0;
    endfunction

    function void push_result(wsdf_pkg::kind_t kind, logic [7:0] data, logic last);
      frame_result_t r;
      r.kind = kind;
      r.data = data;
      r.last = last;
      r.fin = fin;
      r.op = op;
      pending_results.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [1:0] sel;
      logic [7:0] kb;
      case (phase)
        wsdf_pkg::PH_LEN1: begin
          // Client frames must be masked; a clear mask bit is rejected and
          // the next byte is taken as the length byte again.
          if (!b[7]) begin
            push_result(wsdf_pkg::KIND_ERROR, 8'h00, 1'b0);
          end else begin
            hdr_cnt = '0;
            if (b[6:0] == wsdf_pkg::LEN_EXT16) begin
              frame_len = '0;
              phase = wsdf_pkg::PH_LEN2;
            end else if (b[6:0] == wsdf_pkg::LEN_EXT64) begin
              frame_len = '0;
              phase = wsdf_pkg::PH_LEN8;
            end else begin
              frame_len = {57'd0, b[6:0]};
              phase = wsdf_pkg::PH_KEY;
            end
          end
        end
        wsdf_pkg::PH_LEN2, wsdf_pkg::PH_LEN8: begin
          frame_len = {frame_len[55:0], b};
          hdr_cnt = hdr_cnt + 4'd1;
          if (hdr_cnt == ((phase == wsdf_pkg::PH_LEN2) ? wsdf_pkg::LEN16_BYTES
                                                       : wsdf_pkg::LEN64_BYTES)) begin
            hdr_cnt = '0;
            phase = wsdf_pkg::PH_KEY;
          end
        end
        wsdf_pkg::PH_KEY: begin
          key = {key[23:0], b};
          hdr_cnt = hdr_cnt + 4'd1;
          if (hdr_cnt == wsdf_pkg::KEY_BYTES) begin
            hdr_cnt = '0;
            byte_cnt = '0;
            if (frame_len == 64'd0) begin
              phase = wsdf_pkg::PH_START;
              push_result(wsdf_pkg::KIND_EMPTY, 8'h00, 1'b1);
            end else begin
              phase = wsdf_pkg::PH_PAYLOAD;
            end
          end
        end
        wsdf_pkg::PH_PAYLOAD: begin
          sel = byte_cnt[1:0];
          kb = key[31 - 8 * sel -: 8];
          byte_cnt = byte_cnt + 64'd1;
          if (byte_cnt == frame_len) begin
            phase = wsdf_pkg::PH_START;
            push_result(wsdf_pkg::KIND_DATA, b ^ kb, 1'b1);
          end else begin
            push_result(wsdf_pkg::KIND_DATA, b ^ kb, 1'b0);
          end
        end
        default: begin
          if ((b & wsdf_pkg::RSV_MASK) != 8'h00) begin
            push_result(wsdf_pkg::KIND_ERROR, 8'h00, 1'b0);
          end else begin
            fin = b[7];
            op = b[3:0];
            frame_len = '0;
            byte_cnt = '0;
            key = '0;
            hdr_cnt = '0;
            phase = wsdf_pkg::PH_LEN1;
          end
        end
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic last,
                               logic fin_seen, logic [3:0] op_seen);
      frame_result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d data=%02h last=%0b fin=%0b op=%0h",
                   kind, data, last, fin_seen, op_seen);
        return;
      end
      exp_r = pending_results.pop_front();
      if (kind !== exp_r.kind || data !== exp_r.data || last !== exp_r.last ||
          fin_seen !== exp_r.fin || op_seen !== exp_r.op) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected kind=%0d data=%02h last=%0b fin=%0b op=%0h,",
                    " actual kind=%0d data=%02h last=%0b fin=%0b op=%0h"},
                   exp_r.kind, exp_r.data, exp_r.last, exp_r.fin, exp_r.op,
                   kind, data, last, fin_seen, op_seen);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  deframe_scoreboard sb = new();

  int bytes_sent = 0;
  int cycles = 0;
  bit sender_fast = 1'b0;
  bit hold_request = 1'b0;

  // Watchdog. A correct run finishes before this limit is reached, even with
  // the worst idle draws on both sides.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one byte after a random gap and hold it until the block takes it.
  // Right after the edge the block's stall still shows its value from before
  // the edge, so a low stall here means the transfer happened at this edge.
  task automatic put_byte(input logic [7:0] b);
    int gap;
    gap = sender_fast ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // One client frame with random content. Now and then a rejected header or
  // length byte is slipped in first; both leave the parser where it was, so
  // the frame that follows is still parsed as intended. A negative forced_len
  // lets the length be drawn at random.
  task automatic send_frame(input int forced_len);
    int len;
    int pick;
    logic [7:0] b;
    logic [63:0] len64;
    if ($urandom_range(0, 9) == 0) begin
      b = 8'($urandom_range(0, 255));
      b[6:4] = 3'($urandom_range(1, 7));
      put_byte(b);
    end
    b = 8'($urandom_range(0, 255));
    b[6:4] = 3'b000;
    put_byte(b);
    if ($urandom_range(0, 9) == 0) begin
      b = 8'($urandom_range(0, 255));
      b[7] = 1'b0;
      put_byte(b);
    end
    // Most frames are short so that many headers go by. The extended forms
    // also carry lengths that would fit a shorter encoding.
    pick = $urandom_range(0, 9);
    if (forced_len >= 0)
      len = forced_len;
    else if (pick <= 5)
      len = $urandom_range(0, 12);
    else if (pick == 6)
      len = $urandom_range(0, 125);
    else if (pick <= 8)
      len = $urandom_range(0, 300);
    else
      len = $urandom_range(0, 40);
    len64 = 64'(unsigned'(len));
    if (forced_len < 0 && pick >= 7 && pick <= 8) begin
      put_byte({1'b1, wsdf_pkg::LEN_EXT16});
      put_byte(len64[15:8]);
      put_byte(len64[7:0]);
    end else if (forced_len < 0 && pick == 9) begin
      put_byte({1'b1, wsdf_pkg::LEN_EXT64});
      for (int i = 7; i >= 0; i--) put_byte(len64[8 * i +: 8]);
    end else begin
      put_byte({1'b1, len64[6:0]});
    end
    repeat (4) put_byte(8'($urandom_range(0, 255)));
    repeat (len) put_byte(8'($urandom_range(0, 255)));
  endtask

  // Hold the sender until every queued result has been delivered. The input
  // goes idle first so the last byte is not taken again while waiting.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side. Each result gets a random stall first, with stretches where
  // the receiver never stalls. On request it holds off for a long stretch so
  // that the output register stays full and the block stalls its input.
  initial begin
    int stall_cycles;
    int mode_left;
    bit rx_fast;
    mode_left = 0;
    rx_fast = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (mode_left == 0) begin
        rx_fast = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if (hold_request) begin
        hold_request = 1'b0;
        stall_cycles = 400;
      end else begin
        stall_cycles = rx_fast ? 0 : $urandom_range(0, 16);
      end
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_kind, out_data, out_last, out_fin_flag, out_op_code);
    end
  end

  initial begin
    bit long_hold_done;
    bit drain_done;
    logic [7:0] b;
    long_hold_done = 1'b0;
    drain_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. A header byte with all reserved bits set is rejected
    // while fin and opcode still read zero from reset. Then a frame with FIN
    // and opcode 0xF whose first length byte lacks the mask bit, retried with
    // a 64-bit length of two, followed by a zero-length frame that closes
    // right after its key with an empty-frame result.
    put_byte(8'h70);
    put_byte(8'h8F);
    put_byte(8'h7F);
    put_byte({1'b1, wsdf_pkg::LEN_EXT64});
    repeat (7) put_byte(8'h00);
    put_byte(8'h02);
    put_byte(8'hA5);
    put_byte(8'h5A);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h80);
    repeat (4) put_byte(8'hFF);

    // Random frames. The sender switches between gapped and back-to-back
    // stretches frame by frame.
    while (bytes_sent < RANDOM_BYTES) begin
      sender_fast = ($urandom_range(0, 4) == 0);
      if (!long_hold_done && bytes_sent >= 300) begin
        // Back-to-back payload while the receiver sits on a result.
        long_hold_done = 1'b1;
        sender_fast = 1'b1;
        hold_request = 1'b1;
        send_frame(100);
      end else if (!drain_done && bytes_sent >= 700) begin
        drain_done = 1'b1;
        wait_drained();
        send_frame(-1);
      end else begin
        send_frame(-1);
      end
    end

    // A 64-bit length with its top bit set is taken as it is; the frame
    // never ends within the run, so its payload closes the stimulus.
    sender_fast = 1'b0;
    put_byte(8'h82);
    put_byte({1'b1, wsdf_pkg::LEN_EXT64});
    put_byte(8'h80);
    repeat (6) put_byte(8'($urandom_range(0, 255)));
    put_byte(8'h05);
    repeat (4) put_byte(8'($urandom_range(0, 255)));
    repeat (20) begin
      b = 8'($urandom_range(0, 255));
      put_byte(b);
    end

    // Each result is registered in the cycle after its byte is taken, so a
    // short wait after the last one is enough to catch anything extra.
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
